@@ rtl/sats_pkg.sv @@
// Shared types and constants for the sorted array symbol table.
// Used by the controller, the datapath and the top level; no dependencies.

package sats_pkg;

   localparam int OP_W       = 2;
   localparam int FIELD_W    = 16;
   localparam int RANK_W     = 6;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_SELECT = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_RANK      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_SEARCH,
      S_SELECT,
      S_DUMP,
      S_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_COUNT,
      PTR_RANK,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_REQ
   } src_type;

   typedef struct packed {
      logic       capture;
      ptr_op_type ptr_op;
      logic       rd_prev;
      logic       wr_en;
      src_type    wr_src;
      logic       cnt_inc;
      logic       out_load;
      src_type    out_src;
      status_type out_status;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic count_zero;
      logic rank_bad;
      logic ptr_zero;
      logic ptr_last;
      logic key_lt;
      logic key_eq;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/sats_datapath.sv @@
// Datapath of the sorted array symbol table: entry memory, pointer, count,
// captured request fields and the result register. Depends on sats_pkg.

module sats_datapath #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sats_pkg::cmd_type                    cmd,
   output sats_pkg::stat_type                   stat,
   input  logic [sats_pkg::FIELD_W-1:0]         req_key,
   input  logic [sats_pkg::FIELD_W-1:0]         req_value,
   input  logic [sats_pkg::RANK_W-1:0]          req_rank,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   // status
   output logic [sats_pkg::STATUS_W-1:0]        rsp_tuser,
   // found_key, found_value, entry_count, zero fill
   output logic [sats_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import sats_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int ENT_W = KEY_BITS + FIELD_W;

   logic [ENT_W-1:0]    mem [CAPACITY];
   logic [ENT_W-1:0]    rd_ff;
   logic [ENT_W-1:0]    wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [KEY_BITS-1:0] key_ff;
   logic [FIELD_W-1:0]  value_ff;
   logic [KEY_BITS-1:0] rd_key;
   logic [FIELD_W-1:0]  rd_value;

   logic                out_valid_ff, out_valid_in;
   status_type          out_status_ff;
   logic [FIELD_W-1:0]  out_key_ff, out_value_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_last_ff;
   logic [FIELD_W-1:0]  sel_key, sel_value;

   assign rd_key   = rd_ff[ENT_W-1:FIELD_W];
   assign rd_value = rd_ff[FIELD_W-1:0];

   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_CLEAR: ptr_in = '0;
         PTR_COUNT: ptr_in = IDX_W'(count_ff);
         PTR_RANK:  ptr_in = IDX_W'(req_rank);
         PTR_INC:   ptr_in = ptr_ff + 1'b1;
         PTR_DEC:   ptr_in = ptr_ff - 1'b1;
         default:   ptr_in = ptr_ff;
      endcase
   end

   // read one entry ahead so that the walk advances every cycle
   assign rd_addr  = cmd.rd_prev ? (ptr_in - 1'b1) : ptr_in;
   assign wr_data  = (cmd.wr_src == SRC_MEM) ? rd_ff : {key_ff, value_ff};
   assign count_in = cmd.cnt_inc ? (count_ff + 1'b1) : count_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[ptr_ff] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         count_ff <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff   <= KEY_BITS'(req_key);
         value_ff <= req_value;
      end
   end

   assign stat.count_full = (count_ff == CNT_W'(CAPACITY));
   assign stat.count_zero = (count_ff == '0);
   assign stat.rank_bad   = (COUNT_W'(req_rank) >= COUNT_W'(count_ff));
   assign stat.ptr_zero   = (ptr_ff == '0);
   assign stat.ptr_last   = ((CNT_W'(ptr_ff) + 1'b1) == count_ff);
   assign stat.key_lt     = (key_ff < rd_key);
   assign stat.key_eq     = (key_ff == rd_key);
   assign stat.out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      case (cmd.out_src)
         SRC_MEM: begin
            sel_key   = FIELD_W'(rd_key);
            sel_value = rd_value;
         end
         SRC_REQ: begin
            sel_key   = FIELD_W'(key_ff);
            sel_value = value_ff;
         end
         default: begin
            sel_key   = '0;
            sel_value = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         out_key_ff    <= sel_key;
         out_value_ff  <= sel_value;
         out_count_ff  <= COUNT_W'(count_ff);
         out_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {1'b0, out_count_ff, out_value_ff, out_key_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register overwritten while held");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count moved by other than one");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("entry write into a full table");
`endif

endmodule

@@ rtl/sats_controller.sv @@
// Controller state machine of the sorted array symbol table: sequences
// insert shifts, search walks, select and dump. Depends on sats_pkg.

module sats_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sats_pkg::op_type    op,
   input  sats_pkg::stat_type  stat,
   output sats_pkg::cmd_type   cmd
);
   import sats_pkg::*;

   state_type  state_ff, state_in;
   status_type pend_status_ff, pend_status_in;
   src_type    pend_src_ff, pend_src_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_INSERT: state_in = stat.count_full ? S_RESPOND : S_SHIFT;
                  OP_SEARCH: state_in = stat.count_zero ? S_RESPOND : S_SEARCH;
                  OP_SELECT: state_in = stat.rank_bad ? S_RESPOND : S_SELECT;
                  OP_DUMP:   state_in = stat.count_zero ? S_RESPOND : S_DUMP;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SHIFT: begin
            if (stat.ptr_zero || !stat.key_lt) begin
               state_in = S_RESPOND;
            end
         end
         S_SEARCH: begin
            if ((stat.key_eq || stat.key_lt || stat.ptr_last) && stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SELECT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            if (stat.out_free && stat.ptr_last) begin
               state_in = S_IDLE;
            end
         end
         S_RESPOND: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.ptr_op     = PTR_HOLD;
      cmd.wr_src     = SRC_MEM;
      cmd.out_src    = SRC_ZERO;
      cmd.out_status = ST_OK;
      pend_status_in = pend_status_ff;
      pend_src_in    = pend_src_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = accept;
            pend_src_in = SRC_ZERO;
            if (accept) begin
               case (op)
                  OP_INSERT: begin
                     pend_status_in = ST_FULL;
                     cmd.ptr_op     = PTR_COUNT;
                     cmd.rd_prev    = 1'b1;
                  end
                  OP_SEARCH: begin
                     pend_status_in = ST_NOT_FOUND;
                     cmd.ptr_op     = PTR_CLEAR;
                  end
                  OP_SELECT: begin
                     pend_status_in = ST_RANK;
                     cmd.ptr_op     = PTR_RANK;
                  end
                  OP_DUMP: begin
                     pend_status_in = ST_EMPTY;
                     cmd.ptr_op     = PTR_CLEAR;
                  end
                  default: pend_status_in = ST_OK;
               endcase
            end
         end
         S_SHIFT: begin
            cmd.wr_en = 1'b1;
            if (!stat.ptr_zero && stat.key_lt) begin
               // move the larger entry up and look one further down
               cmd.wr_src  = SRC_MEM;
               cmd.ptr_op  = PTR_DEC;
               cmd.rd_prev = 1'b1;
            end else begin
               cmd.wr_src     = SRC_REQ;
               cmd.cnt_inc    = 1'b1;
               pend_status_in = ST_OK;
               pend_src_in    = SRC_REQ;
            end
         end
         S_SEARCH: begin
            cmd.out_last = 1'b1;
            if (stat.key_eq) begin
               cmd.out_load   = stat.out_free;
               cmd.out_src    = SRC_MEM;
               cmd.out_status = ST_OK;
            end else if (stat.key_lt || stat.ptr_last) begin
               cmd.out_load   = stat.out_free;
               cmd.out_src    = SRC_ZERO;
               cmd.out_status = ST_NOT_FOUND;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_SELECT: begin
            cmd.out_load   = stat.out_free;
            cmd.out_src    = SRC_MEM;
            cmd.out_status = ST_OK;
            cmd.out_last   = 1'b1;
         end
         S_DUMP: begin
            cmd.out_load   = stat.out_free;
            cmd.out_src    = SRC_MEM;
            cmd.out_status = ST_OK;
            cmd.out_last   = stat.ptr_last;
            if (stat.out_free && !stat.ptr_last) begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_RESPOND: begin
            cmd.out_load   = stat.out_free;
            cmd.out_src    = pend_src_ff;
            cmd.out_status = pend_status_ff;
            cmd.out_last   = 1'b1;
         end
         default: begin
            cmd.ptr_op = PTR_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_src_ff    <= pend_src_in;
   end

endmodule

@@ rtl/sorted_array_symbol_table.sv @@
// Top level of the sorted array symbol table: controller plus datapath.
// Depends on sats_pkg, sats_controller and sats_datapath.
//
// Usage:
//   req channel: one item per operation. req_tuser carries op (insert,
//   search, select, dump); req_tdata carries item_key, item_value, rank.
//   rsp channel: req_tuser-style status in rsp_tuser; rsp_tdata carries
//   found_key, found_value and the entry count after the operation;
//   rsp_tlast marks the final result of an item.
//   Insert, search and select give one result; dump gives one result per
//   stored entry in ascending key order (one empty-status result if none).
// Insert moves entries up with one read and one write per cycle in the
//   shift loop; search walks the entries; dump gives one entry per cycle
//   from the single read port while the receiver is ready. A new item is
//   taken once the previous one has placed its last result in the output
//   register.
// Reset clears the entry count and the handshake state; stored entries are
// not cleared, and no clearing pass is needed. A stalled receiver holds the
// result register, and the walk or dump pauses until it frees up.

module sorted_array_symbol_table #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // op
   input  logic [sats_pkg::OP_W-1:0]            req_tuser,
   // item_key, item_value, rank, zero fill
   input  logic [sats_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status
   output logic [sats_pkg::STATUS_W-1:0]        rsp_tuser,
   // found_key, found_value, entry_count, zero fill
   output logic [sats_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import sats_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   op_type   op;

   assign op = op_type'(req_tuser);

   sats_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (op),
      .stat       (stat),
      .cmd        (cmd)
   );

   sats_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_key    (req_tdata[15:0]),
      .req_value  (req_tdata[31:16]),
      .req_rank   (req_tdata[37:32]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
